/* src/sprt_pkg.sv */
`default_nettype none

package sprt_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 64;
    localparam int PAGE_BYTES    = 4096;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;

    // Field widths fixed by the interface
    localparam int KEY_W   = 32;
    localparam int FRAME_W = 20;
    localparam int SIZE_W  = 31;
    localparam int ADDR_W  = 32;
    localparam int REFS_W  = 8;
    localparam int SLOT_W  = 6;
    localparam int STAT_W  = 3;

    localparam logic [REFS_W-1:0] REFS_MAX = {REFS_W{1'b1}};

    // Action codes
    localparam logic ACT_OPEN  = 1'b0;
    localparam logic ACT_CLOSE = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OPEN_OLD  = 3'd0;
    localparam logic [STAT_W-1:0] ST_OPEN_NEW  = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_CLOSED    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STAT_W-1:0] ST_INVALID   = 3'd5;

    typedef struct packed {
        logic               action;
        logic [KEY_W-1:0]   seg_id;
        logic [FRAME_W-1:0] fresh_frame;
        logic [SIZE_W-1:0]  proc_size;
    } sprt_req_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [SLOT_W-1:0]  slot;
        logic [FRAME_W-1:0] frame_page;
        logic [ADDR_W-1:0]  virt_addr;
        logic [REFS_W-1:0]  ref_count;
        logic               released;
    } sprt_rsp_t;

    // One stored table entry
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [FRAME_W-1:0] frame;
        logic [REFS_W-1:0]  refs;
    } sprt_entry_t;

    // Read return from the entry store
    typedef struct packed {
        logic        valid;
        sprt_entry_t entry;
    } sprt_rd_t;

    // Write request into the entry store
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic             valid;
        sprt_entry_t      entry;
    } sprt_wr_t;

endpackage

`default_nettype wire

/* src/sprt_store.sv */
`default_nettype none

module sprt_store (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic [sprt_pkg::IDX_W-1:0] rd_idx,
    output sprt_pkg::sprt_rd_t           rd,
    input  wire sprt_pkg::sprt_wr_t      wr
);
    import sprt_pkg::*;

    sprt_entry_t               mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]  valid_reg;
    sprt_entry_t               rd_entry_reg;
    logic                      rd_valid_reg;

    // Write entry payload
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.entry;
        end
    end

    // Registered read of payload
    always_ff @(posedge clk)
    begin
        rd_entry_reg <= mem[rd_idx];
    end

    // Hold valid bits in flops so reset clears the table at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.idx] <= wr.valid;
            end
            rd_valid_reg <= valid_reg[rd_idx];
        end
    end

    assign rd.valid = rd_valid_reg;
    assign rd.entry = rd_entry_reg;

endmodule

`default_nettype wire

/* src/sprt_ctrl.sv */
`default_nettype none

module sprt_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire sprt_pkg::sprt_req_t     req,
    output logic                         done,
    output sprt_pkg::sprt_rsp_t          rsp,
    output logic [sprt_pkg::IDX_W-1:0]   rd_idx,
    input  wire sprt_pkg::sprt_rd_t      rd,
    output sprt_pkg::sprt_wr_t           wr
);
    import sprt_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;

    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);
    localparam logic [ADDR_W-1:0] PG_MASK = ADDR_W'(PAGE_BYTES - 1);

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    sprt_req_t          req_reg, req_next;

    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    sprt_entry_t        hit_ent_reg, hit_ent_next;
    logic               free_reg, free_next;
    logic [IDX_W-1:0]   free_idx_reg, free_idx_next;

    logic               done_reg, done_next;
    sprt_rsp_t          rsp_reg, rsp_next;

    logic               accept;
    logic [ADDR_W-1:0]  va;
    logic [REFS_W-1:0]  refs_inc;
    logic [REFS_W-1:0]  refs_dec;

    assign accept = start && (state_reg == S_IDLE);
    assign rd_idx = cnt_reg[IDX_W-1:0];

    // Round process size up to a page boundary
    assign va       = (ADDR_W'(req_reg.proc_size) + PG_MASK) & ~PG_MASK;
    assign refs_inc = hit_ent_reg.refs + REFS_W'(1);
    assign refs_dec = hit_ent_reg.refs - REFS_W'(1);

    // Sequencer: scan one entry a cycle, then decide and write back
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = rd_idx;
        req_next      = req_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_ent_next  = hit_ent_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        wr            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next  = req;
                    cnt_next  = '0;
                    hit_next  = 1'b0;
                    free_next = 1'b0;
                    state_next = (req.seg_id == '0) ? S_DECIDE : S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Issue next read
                if (cnt_reg != CNT_END)
                begin
                    cmp_vld_next = 1'b1;
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_DECIDE;
                end
                // Compare the entry read last cycle
                if (cmp_vld_reg)
                begin
                    if (rd.valid && (rd.entry.key == req_reg.seg_id) && !hit_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = cmp_idx_reg;
                        hit_ent_next = rd.entry;
                    end
                    if (!rd.valid && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = cmp_idx_reg;
                    end
                end
            end

            S_DECIDE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                rsp_next   = '0;
                if (req_reg.seg_id == '0)
                begin
                    rsp_next.status = ST_INVALID;
                end
                else if (req_reg.action == ACT_OPEN)
                begin
                    if (hit_reg)
                    begin
                        rsp_next.slot       = SLOT_W'(hit_idx_reg);
                        rsp_next.frame_page = hit_ent_reg.frame;
                        if (hit_ent_reg.refs == REFS_MAX)
                        begin
                            rsp_next.status    = ST_INVALID;
                            rsp_next.ref_count = REFS_MAX;
                        end
                        else
                        begin
                            rsp_next.status    = ST_OPEN_OLD;
                            rsp_next.ref_count = refs_inc;
                            rsp_next.virt_addr = va;
                            wr.en         = 1'b1;
                            wr.idx        = hit_idx_reg;
                            wr.valid      = 1'b1;
                            wr.entry      = hit_ent_reg;
                            wr.entry.refs = refs_inc;
                        end
                    end
                    else if (free_reg)
                    begin
                        rsp_next.status     = ST_OPEN_NEW;
                        rsp_next.slot       = SLOT_W'(free_idx_reg);
                        rsp_next.frame_page = req_reg.fresh_frame;
                        rsp_next.virt_addr  = va;
                        rsp_next.ref_count  = REFS_W'(1);
                        wr.en          = 1'b1;
                        wr.idx         = free_idx_reg;
                        wr.valid       = 1'b1;
                        wr.entry.key   = req_reg.seg_id;
                        wr.entry.frame = req_reg.fresh_frame;
                        wr.entry.refs  = REFS_W'(1);
                    end
                    else
                    begin
                        rsp_next.status = ST_FULL;
                    end
                end
                else
                begin
                    if (hit_reg)
                    begin
                        rsp_next.status     = ST_CLOSED;
                        rsp_next.slot       = SLOT_W'(hit_idx_reg);
                        rsp_next.frame_page = hit_ent_reg.frame;
                        wr.en  = 1'b1;
                        wr.idx = hit_idx_reg;
                        if (hit_ent_reg.refs <= REFS_W'(1))
                        begin
                            // Free the entry
                            rsp_next.released = 1'b1;
                            wr.valid          = 1'b0;
                            wr.entry          = '0;
                        end
                        else
                        begin
                            rsp_next.ref_count = refs_dec;
                            wr.valid      = 1'b1;
                            wr.entry      = hit_ent_reg;
                            wr.entry.refs = refs_dec;
                        end
                    end
                    else
                    begin
                        rsp_next.status = ST_NOT_FOUND;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
            free_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cmp_vld_reg <= cmp_vld_next;
            hit_reg     <= hit_next;
            free_reg    <= free_next;
            done_reg    <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        req_reg      <= req_next;
        hit_idx_reg  <= hit_idx_next;
        hit_ent_reg  <= hit_ent_next;
        free_idx_reg <= free_idx_next;
        rsp_reg      <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

/* src/shared_page_refcount_table.sv */
`default_nettype none

// Channel   Handshake           Payload
// request   start / busy        req  (sprt_req_t), taken when start && !busy
// result    done (one cycle)    rsp  (sprt_rsp_t), valid only while done is high
//
// Every request with a nonzero segment id scans the whole table, one entry per
// cycle through the store's single read port, then decides and writes back in
// the DECIDE state; done goes high as busy goes low.
// A request with segment id zero skips the scan and goes straight to DECIDE.
// Reset clears the valid bits directly, so no clearing pass is needed.
// The result receiver cannot stall; a new start may be taken in the done cycle.

module shared_page_refcount_table (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire sprt_pkg::sprt_req_t req,
    output logic                done,
    output sprt_pkg::sprt_rsp_t rsp
);
    import sprt_pkg::*;

    logic [IDX_W-1:0] rd_idx;
    sprt_rd_t         rd;
    sprt_wr_t         wr;

    // Sequencer with the shared key compare
    sprt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .rsp    (rsp),
        .rd_idx (rd_idx),
        .rd     (rd),
        .wr     (wr)
    );

    // Entry table
    sprt_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_idx (rd_idx),
        .rd     (rd),
        .wr     (wr)
    );

endmodule

`default_nettype wire

/* bench/sprt_checker.sv */
`default_nettype none

module sprt_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire sprt_pkg::sprt_req_t req,
    input  wire logic                done,
    input  wire sprt_pkg::sprt_rsp_t rsp,
    output int                       mismatches,
    output int                       pending,
    output int                       checked,
    output logic [5:0]               status_seen
);
    import sprt_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the page table
    logic               shadow_valid [TABLE_ENTRIES];
    logic [KEY_W-1:0]   shadow_key   [TABLE_ENTRIES];
    logic [FRAME_W-1:0] shadow_frame [TABLE_ENTRIES];
    logic [REFS_W-1:0]  shadow_refs  [TABLE_ENTRIES];

    sprt_rsp_t predicted_rsp_q [$];

    // Apply one open or close to the shadow table and form its response
    task automatic apply_table_op(input sprt_req_t r, output sprt_rsp_t e);
        int                hit;
        int                free_idx;
        logic [ADDR_W-1:0] sum;
        logic [ADDR_W-1:0] va;
        e        = '0;
        hit      = -1;
        free_idx = -1;
        sum      = ADDR_W'(r.proc_size) + ADDR_W'(PAGE_BYTES - 1);
        va       = sum & ~ADDR_W'(PAGE_BYTES - 1);
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (hit < 0 && shadow_valid[i] && shadow_key[i] == r.seg_id)
                hit = i;
            if (free_idx < 0 && !shadow_valid[i])
                free_idx = i;
        end
        if (r.seg_id == '0)
        begin
            e.status = ST_INVALID;
        end
        else if (r.action == ACT_OPEN)
        begin
            if (hit >= 0 && shadow_refs[hit] == REFS_MAX)
            begin
                // Saturated count: report the entry, leave it alone
                e.status     = ST_INVALID;
                e.slot       = SLOT_W'(hit);
                e.frame_page = shadow_frame[hit];
                e.ref_count  = REFS_MAX;
            end
            else if (hit >= 0)
            begin
                shadow_refs[hit] = shadow_refs[hit] + 1'b1;
                e.status     = ST_OPEN_OLD;
                e.slot       = SLOT_W'(hit);
                e.frame_page = shadow_frame[hit];
                e.virt_addr  = va;
                e.ref_count  = shadow_refs[hit];
            end
            else if (free_idx < 0)
            begin
                e.status = ST_FULL;
            end
            else
            begin
                shadow_valid[free_idx] = 1'b1;
                shadow_key[free_idx]   = r.seg_id;
                shadow_frame[free_idx] = r.fresh_frame;
                shadow_refs[free_idx]  = REFS_W'(1);
                e.status     = ST_OPEN_NEW;
                e.slot       = SLOT_W'(free_idx);
                e.frame_page = r.fresh_frame;
                e.virt_addr  = va;
                e.ref_count  = REFS_W'(1);
            end
        end
        else if (hit < 0)
        begin
            e.status = ST_NOT_FOUND;
        end
        else
        begin
            e.status     = ST_CLOSED;
            e.slot       = SLOT_W'(hit);
            e.frame_page = shadow_frame[hit];
            if (shadow_refs[hit] <= REFS_W'(1))
            begin
                // Last reference gone: free the entry
                shadow_valid[hit] = 1'b0;
                shadow_key[hit]   = '0;
                shadow_frame[hit] = '0;
                shadow_refs[hit]  = '0;
                e.released        = 1'b1;
            end
            else
            begin
                shadow_refs[hit] = shadow_refs[hit] - 1'b1;
                e.ref_count      = shadow_refs[hit];
            end
        end
    endtask

    // Compare each result, then predict each accepted transaction
    always @(posedge clk or negedge rst_n)
    begin
        sprt_rsp_t exp_rsp;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                shadow_valid[i] = 1'b0;
                shadow_key[i]   = '0;
                shadow_frame[i] = '0;
                shadow_refs[i]  = '0;
            end
            predicted_rsp_q.delete();
            mismatches  <= 0;
            pending     <= 0;
            checked     <= 0;
            status_seen <= '0;
        end
        else
        begin
            if (done)
            begin
                if (predicted_rsp_q.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("%0t: result with nothing outstanding: st %0d slot %0d",
                                 $time, rsp.status, rsp.slot);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    exp_rsp = predicted_rsp_q.pop_front();
                    if (rsp !== exp_rsp)
                    begin
                        if (mismatches < REPORT_LIMIT)
                        begin
                            $display({"%0t: mismatch, expected st %0d slot %0d",
                                      " frame %h va %h refs %0d rel %b"},
                                     $time, exp_rsp.status, exp_rsp.slot,
                                     exp_rsp.frame_page, exp_rsp.virt_addr,
                                     exp_rsp.ref_count, exp_rsp.released);
                            $display({"%0t:           actual   st %0d slot %0d",
                                      " frame %h va %h refs %0d rel %b"},
                                     $time, rsp.status, rsp.slot, rsp.frame_page,
                                     rsp.virt_addr, rsp.ref_count, rsp.released);
                        end
                        mismatches <= mismatches + 1;
                    end
                    if (exp_rsp.status <= ST_INVALID)
                        status_seen[exp_rsp.status] <= 1'b1;
                    checked <= checked + 1;
                end
            end
            if (start && !busy)
            begin
                apply_table_op(req, exp_rsp);
                predicted_rsp_q.push_back(exp_rsp);
            end
            pending <= predicted_rsp_q.size();
        end
    end

endmodule

`default_nettype wire

/* bench/testbench.sv */
`default_nettype none

module testbench;
    import sprt_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int POOL_SIZE      = 10;
    localparam int FILL_COUNT     = 70;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    sprt_req_t req;
    logic      done;
    sprt_rsp_t rsp;

    int         mismatches;
    int         pending;
    int         checked;
    logic [5:0] status_seen;

    int sent;
    int burst_left;
    int idle_cycles;

    logic [KEY_W-1:0] key_pool  [POOL_SIZE];
    logic [KEY_W-1:0] fill_keys [FILL_COUNT];
    logic [KEY_W-1:0] sat_key;
    logic [KEY_W-1:0] pick;
    int               sel;

    shared_page_refcount_table i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    sprt_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .pending     (pending),
        .checked     (checked),
        .status_seen (status_seen)
    );

    // Free-running clock
    always #2 clk = ~clk;

    // End the run if no transaction moves for too long
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("Verification failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic sprt_req_t random_req();
        sprt_req_t r;
        r.action      = 1'($urandom);
        r.seg_id      = $urandom;
        r.fresh_frame = FRAME_W'($urandom);
        r.proc_size   = SIZE_W'($urandom);
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        k = $urandom;
        while (k == '0)
            k = $urandom;
        return k;
    endfunction

    function automatic sprt_req_t make_req(logic act, logic [KEY_W-1:0] key,
                                           logic [FRAME_W-1:0] frame,
                                           logic [SIZE_W-1:0] size);
        sprt_req_t r;
        r.action      = act;
        r.seg_id      = key;
        r.fresh_frame = frame;
        r.proc_size   = size;
        return r;
    endfunction

    // Hand one transaction to the block, idling between bursts
    task automatic issue(input sprt_req_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap)
                begin
                    req <= random_req();
                    @(posedge clk);
                end
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        sent++;
    endtask

    task automatic issue_op(input logic act, input logic [KEY_W-1:0] key);
        sprt_req_t r;
        r        = random_req();
        r.action = act;
        r.seg_id = key;
        issue(r);
    endtask

    // Hold off until every outstanding result has come back
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        burst_left = 0;
    endtask

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        req        = '0;
        sent       = 0;
        burst_left = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero id, unknown close, field extremes, reuse of lowest slot
        issue(make_req(ACT_OPEN, '0, '1, '1));
        issue(make_req(ACT_CLOSE, '0, '1, '1));
        issue(make_req(ACT_CLOSE, 32'h1234_5678, 20'h12345, 31'd100));
        issue(make_req(ACT_OPEN, 32'hFFFF_FFFF, 20'hFFFFF, 31'd0));
        issue(make_req(ACT_OPEN, 32'hFFFF_FFFF, 20'h00000, 31'd1));
        issue(make_req(ACT_OPEN, 32'hFFFF_FFFF, 20'h11111, 31'h7FFF_FFFF));
        issue(make_req(ACT_OPEN, 32'h0000_0001, 20'h00000, 31'd4096));
        issue(make_req(ACT_OPEN, 32'h8000_0000, 20'h5A5A5, 31'd4097));
        issue(make_req(ACT_CLOSE, 32'h0000_0001, 20'hFFFFF, 31'h7FFF_FFFF));
        issue(make_req(ACT_OPEN, 32'hA5A5_5A5A, 20'hA5A5A, 31'd4095));
        issue(make_req(ACT_CLOSE, 32'hFFFF_FFFF, 20'h0, 31'd0));
        issue(make_req(ACT_CLOSE, 32'hFFFF_FFFF, 20'h0, 31'd0));
        issue(make_req(ACT_CLOSE, 32'hFFFF_FFFF, 20'h0, 31'd0));
        issue(make_req(ACT_CLOSE, 32'hFFFF_FFFF, 20'h0, 31'd0));
        issue(make_req(ACT_OPEN, 32'h8000_0000, 20'hFFFFF, 31'd8191));
        issue(make_req(ACT_CLOSE, 32'h8000_0000, 20'h0, 31'd0));
        issue(make_req(ACT_CLOSE, 32'h8000_0000, 20'h0, 31'd0));
        issue(make_req(ACT_CLOSE, 32'hA5A5_5A5A, 20'h0, 31'd0));
        issue(make_req(ACT_CLOSE, 32'h7FFF_FFFF, 20'hFFFFF, 31'h7FFF_FFFF));
        drain();

        // Random mix over a small key pool, with fresh and zero ids mixed in
        key_pool[0] = 32'hFFFF_FFFF;
        for (int i = 1; i < POOL_SIZE; i++)
            key_pool[i] = fresh_key();
        for (int n = 0; n < 200; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 85)
                pick = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (sel < 93)
                pick = fresh_key();
            else
                pick = '0;
            issue_op(($urandom_range(0, 9) < 6) ? ACT_OPEN : ACT_CLOSE, pick);
        end
        drain();

        // Drive one entry into count saturation and back
        sat_key = fresh_key();
        repeat (257)
            issue_op(ACT_OPEN, sat_key);
        issue_op(ACT_CLOSE, sat_key);
        issue_op(ACT_OPEN, sat_key);
        issue_op(ACT_OPEN, sat_key);

        // Fill the table past capacity, then churn it
        for (int i = 0; i < FILL_COUNT; i++)
        begin
            fill_keys[i] = fresh_key();
            issue_op(ACT_OPEN, fill_keys[i]);
        end
        for (int n = 0; n < 25; n++)
        begin
            sel = $urandom_range(0, 2);
            if (sel == 0)
                issue_op(ACT_CLOSE, fill_keys[$urandom_range(0, FILL_COUNT - 1)]);
            else if (sel == 1)
                issue_op(ACT_OPEN, fill_keys[$urandom_range(0, FILL_COUNT - 1)]);
            else
                issue_op(ACT_OPEN, fresh_key());
        end

        // Let the last results arrive, then give the verdict
        drain();
        repeat (TABLE_ENTRIES + 8) @(posedge clk);
        $display("Summary: %0d requests sent, %0d results checked, %0d mismatches",
                 sent, checked, mismatches);
        $display("Summary: status codes seen (bit n = code n): %b; table filled and one count saturated",
                 status_seen);
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
